// ===== hdl/bf3_pkg.sv =====
// Shared types, constants and the small-divisor mean function for the 3x3 box filter.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package bf3_pkg;

   localparam int MaxWidth  = 256;
   localparam int MaxHeight = 4096;

   localparam int PixW   = 8;
   localparam int ColW   = $clog2(MaxWidth);
   localparam int RowW   = $clog2(MaxHeight);
   localparam int WidthW = 9;
   localparam int HeightW = 13;
   localparam int SumW   = 12;
   localparam int CntW   = 4;
   localparam int DataW  = 32;
   localparam int AddrW  = 3;

   localparam logic [WidthW-1:0]  WidthLimit  = WidthW'(MaxWidth);
   localparam logic [HeightW-1:0] HeightLimit = HeightW'(MaxHeight);
   localparam logic [WidthW-1:0]  WidthReset  = WidthW'(256);
   localparam logic [HeightW-1:0] HeightReset = HeightW'(256);

   // input command codes
   localparam logic CmdPush  = 1'b0;
   localparam logic CmdDrain = 1'b1;

   // reciprocals for floor division by 3 and 9 (exact for sums below 8192)
   localparam int Recip3      = 2731;
   localparam int Recip3Shift = 13;
   localparam int Recip9      = 3641;
   localparam int Recip9Shift = 15;
   localparam int ProdW       = 2 * SumW;

   typedef struct packed {
      logic push_rd;      // transfer of a push: read line stores at current column
      logic push_shift;   // shift window, write line stores, advance position
      logic sum_first;    // load sum of the interior output region
      logic sum_second;   // load sum of the row-end output region
      logic drain_init;   // transfer of a drain: clear accumulator, set column
      logic drain_rd;     // read line stores at drain column
      logic drain_acc;    // accumulate read data
      logic out_load;     // load the output register
      logic out_row_end;  // push output is the row-end one
      logic out_drain;    // output comes from the drain path
   } bf3_cmd_type;

   typedef struct packed {
      logic draining;
      logic emit_first;
      logic emit_second;
      logic drain_col_done;
      logic out_free;
   } bf3_sts_type;

   function automatic logic [PixW-1:0] mean_div(input logic [SumW-1:0] s,
                                                input logic [CntW-1:0] n);
      logic [ProdW-1:0] p3;
      logic [ProdW-1:0] p9;
      logic [SumW-1:0]  q;
      p3 = {{(ProdW-SumW){1'b0}}, s} * ProdW'(Recip3);
      p9 = {{(ProdW-SumW){1'b0}}, s} * ProdW'(Recip9);
      case (n)
         4'd1:    q = s;
         4'd2:    q = s >> 1;
         4'd3:    q = SumW'(p3 >> Recip3Shift);
         4'd4:    q = s >> 2;
         4'd6:    q = SumW'(p3 >> (Recip3Shift + 1));
         4'd9:    q = SumW'(p9 >> Recip9Shift);
         default: q = '0;
      endcase
      return q[PixW-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/bf3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/bf3_ctrl.sv =====
// Sequencing state machine for the 3x3 box filter: push, output and drain steps.
// Depends on bf3_pkg; drives the datapath through bf3_cmd_type.
`timescale 1ns / 1ps
`default_nettype none

module bf3_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_command,
   output logic                      req_stall,
   output bf3_pkg::bf3_cmd_type      cmd,
   input  wire bf3_pkg::bf3_sts_type sts
);
   import bf3_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_PSHIFT = 4'd1;
   localparam logic [3:0] S_PSUM1  = 4'd2;
   localparam logic [3:0] S_PDIV1  = 4'd3;
   localparam logic [3:0] S_PSUM2  = 4'd4;
   localparam logic [3:0] S_PDIV2  = 4'd5;
   localparam logic [3:0] S_DRD    = 4'd6;
   localparam logic [3:0] S_DACC   = 4'd7;
   localparam logic [3:0] S_DDIV   = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_command == CmdPush && !sts.draining) begin
                  cmd.push_rd = 1'b1;
                  state_in    = S_PSHIFT;
               end else if (req_command == CmdDrain && sts.draining) begin
                  cmd.drain_init = 1'b1;
                  state_in       = S_DRD;
               end
            end
         end
         S_PSHIFT: begin
            cmd.push_shift = 1'b1;
            state_in       = S_PSUM1;
         end
         S_PSUM1: begin
            if (sts.emit_first) begin
               cmd.sum_first = 1'b1;
               state_in      = S_PDIV1;
            end else if (sts.emit_second) begin
               cmd.sum_second = 1'b1;
               state_in       = S_PDIV2;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PDIV1: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = sts.emit_second ? S_PSUM2 : S_IDLE;
            end
         end
         S_PSUM2: begin
            cmd.sum_second = 1'b1;
            state_in       = S_PDIV2;
         end
         S_PDIV2: begin
            if (sts.out_free) begin
               cmd.out_load    = 1'b1;
               cmd.out_row_end = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_DRD: begin
            cmd.drain_rd = 1'b1;
            state_in     = S_DACC;
         end
         S_DACC: begin
            cmd.drain_acc = 1'b1;
            state_in      = sts.drain_col_done ? S_DDIV : S_DRD;
         end
         S_DDIV: begin
            if (sts.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_drain = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/bf3_dp.sv =====
// Datapath of the 3x3 box filter: line stores, window, positions, mean and output register.
// Depends on bf3_pkg and bf3_ram; commanded by bf3_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module bf3_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [bf3_pkg::PixW-1:0]            req_pixel,
   input  wire logic [bf3_pkg::WidthW-1:0]          image_width,
   input  wire logic [bf3_pkg::HeightW-1:0]         image_height,
   input  wire bf3_pkg::bf3_cmd_type                cmd,
   output bf3_pkg::bf3_sts_type                     sts,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [bf3_pkg::PixW-1:0]            rsp_smoothed,
   output logic                                     rsp_row_end,
   output logic                                     rsp_image_end
);
   import bf3_pkg::*;

   logic [WidthW-1:0]  w_eff;
   logic [HeightW-1:0] h_eff;

   logic [ColW-1:0] in_col_ff, in_col_in;
   logic [RowW-1:0] in_row_ff, in_row_in;
   logic [ColW-1:0] drain_col_ff, drain_col_in;
   logic            draining_ff, draining_in;
   logic [PixW-1:0] pixel_ff;
   logic [ColW-1:0] x_ff, x_in;
   logic [SumW-1:0] sum_ff, sum_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            top_ff, c_ge1_ff, c_ge2_ff, emit_first_ff, emit_second_ff;
   logic [PixW-1:0] win_ff [3][3];
   logic [PixW-1:0] win_in [3][3];

   logic            rsp_valid_ff, rsp_valid_in;
   logic [PixW-1:0] smoothed_ff;
   logic            row_end_ff, image_end_ff;

   logic [PixW-1:0] above_rd, two_rd;
   logic [ColW-1:0] rd_addr;
   logic            rd_en;

   logic            col_at_end, row_at_end;
   logic [ColW-1:0] drain_lo, drain_hi;
   logic            drain_last;
   logic            row_ge1;
   logic [SumW-1:0] win_sum;
   logic [CntW-1:0] win_cnt;
   logic            out_free;

   // clamp configuration to the supported range
   always_comb begin
      w_eff = image_width;
      if (image_width == '0) begin
         w_eff = WidthW'(1);
      end else if (image_width > WidthLimit) begin
         w_eff = WidthLimit;
      end
      h_eff = image_height;
      if (image_height == '0) begin
         h_eff = HeightW'(1);
      end else if (image_height > HeightLimit) begin
         h_eff = HeightLimit;
      end
   end

   assign col_at_end = {1'b0, in_col_ff} >= (w_eff - WidthW'(1));
   assign row_at_end = HeightW'(in_row_ff) >= (h_eff - HeightW'(1));
   assign row_ge1    = (in_row_ff != '0);
   assign drain_lo   = (drain_col_ff != '0) ? drain_col_ff - ColW'(1) : drain_col_ff;
   assign drain_hi   = (({1'b0, drain_col_ff} + WidthW'(1)) < w_eff) ?
                       drain_col_ff + ColW'(1) : drain_col_ff;
   assign drain_last = {1'b0, drain_col_ff} >= (w_eff - WidthW'(1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // line stores
   assign rd_en   = cmd.push_rd | cmd.drain_rd;
   assign rd_addr = cmd.push_rd ? in_col_ff : x_ff;

   bf3_ram #(.WIDTH(PixW), .DEPTH(MaxWidth)) u_line_above (
      .clock   (clock),
      .wr_en   (cmd.push_shift),
      .wr_addr (in_col_ff),
      .wr_data (pixel_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (above_rd)
   );

   bf3_ram #(.WIDTH(PixW), .DEPTH(MaxWidth)) u_line_two_above (
      .clock   (clock),
      .wr_en   (cmd.push_shift),
      .wr_addr (in_col_ff),
      .wr_data (above_rd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (two_rd)
   );

   // masked sum over the window region of the selected output
   always_comb begin
      logic [2:0] rm;
      logic [2:0] cm;
      win_sum = '0;
      win_cnt = '0;
      rm = {1'b1, 1'b1, !top_ff};
      if (cmd.sum_second) begin
         cm = {1'b1, c_ge1_ff, 1'b0};
      end else begin
         cm = {1'b1, 1'b1, c_ge2_ff};
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (rm[r] && cm[c]) begin
               win_sum = win_sum + SumW'(win_ff[r][c]);
               win_cnt = win_cnt + CntW'(1);
            end
         end
      end
   end

   always_comb begin
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      drain_col_in = drain_col_ff;
      draining_in  = draining_ff;
      x_in         = x_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      win_in       = win_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.push_shift) begin
         for (int k = 0; k < 3; k++) begin
            win_in[k][0] = win_ff[k][1];
            win_in[k][1] = win_ff[k][2];
         end
         win_in[0][2] = two_rd;
         win_in[1][2] = above_rd;
         win_in[2][2] = pixel_ff;
         if (col_at_end) begin
            if (row_at_end) begin
               draining_in  = 1'b1;
               drain_col_in = '0;
            end else begin
               in_row_in = in_row_ff + RowW'(1);
            end
            in_col_in = '0;
         end else begin
            in_col_in = in_col_ff + ColW'(1);
         end
      end

      if (cmd.sum_first || cmd.sum_second) begin
         sum_in = win_sum;
         cnt_in = win_cnt;
      end else if (cmd.drain_init) begin
         sum_in = '0;
         cnt_in = '0;
         x_in   = drain_lo;
      end else if (cmd.drain_acc) begin
         sum_in = sum_ff + SumW'(above_rd) + (row_ge1 ? SumW'(two_rd) : SumW'(0));
         cnt_in = cnt_ff + (row_ge1 ? CntW'(2) : CntW'(1));
         if (x_ff != drain_hi) begin
            x_in = x_ff + ColW'(1);
         end
      end

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         if (cmd.out_drain) begin
            if (drain_last) begin
               draining_in  = 1'b0;
               drain_col_in = '0;
               in_row_in    = '0;
               in_col_in    = '0;
            end else begin
               drain_col_in = drain_col_ff + ColW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         drain_col_ff <= '0;
         draining_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         drain_col_ff <= drain_col_in;
         draining_ff  <= draining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_rd) begin
         pixel_ff <= req_pixel;
      end
      // region flags follow the position the pixel arrived at
      if (cmd.push_shift) begin
         top_ff         <= (in_row_ff < RowW'(2));
         c_ge1_ff       <= (in_col_ff >= ColW'(1));
         c_ge2_ff       <= (in_col_ff >= ColW'(2));
         emit_first_ff  <= row_ge1 && (in_col_ff != '0);
         emit_second_ff <= row_ge1 && col_at_end;
      end
      x_ff   <= x_in;
      sum_ff <= sum_in;
      cnt_ff <= cnt_in;
      win_ff <= win_in;
      if (cmd.out_load) begin
         smoothed_ff  <= mean_div(sum_ff, cnt_ff);
         row_end_ff   <= cmd.out_drain ? drain_last : cmd.out_row_end;
         image_end_ff <= cmd.out_drain && drain_last;
      end
   end

   always_comb begin
      sts.draining       = draining_ff;
      sts.emit_first     = emit_first_ff;
      sts.emit_second    = emit_second_ff;
      sts.drain_col_done = (x_ff == drain_hi);
      sts.out_free       = out_free;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_smoothed  = smoothed_ff;
   assign rsp_row_end   = row_end_ff;
   assign rsp_image_end = image_end_ff;

endmodule

`default_nettype wire

// ===== hdl/box_filter_3x3_edge_mean_top.sv =====
// Streaming 3x3 mean blur for 8-bit grayscale pixels, with an APB-style size register file.
// Pushing pixel (r, c) emits the output for (r-1, c-1) and, at row end, (r-1, W-1); drain
// commands after the last pixel emit the final row. Each output is the floor of the mean of the
// neighbours inside the image. The block works on one item at a time: an ignored command is
// taken and dropped; a push reads the line stores, shifts the window, then sums and loads each
// output it emits, the second output needing a sum step of its own; a drain reads and
// accumulates each of n columns from the line stores, n being 1 to 3, each read with registered
// data, then loads its output. A full output register that is held by rsp_stall adds waits.
// Requires bf3_pkg, bf3_ctrl, bf3_dp and bf3_ram. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module box_filter_3x3_edge_mean_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_command,
   input  wire logic [bf3_pkg::PixW-1:0]    req_pixel,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [bf3_pkg::PixW-1:0]    rsp_smoothed,
   output logic                             rsp_row_end,
   output logic                             rsp_image_end,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [bf3_pkg::AddrW-1:0]   paddr,
   input  wire logic [bf3_pkg::DataW-1:0]   pwdata,
   output logic      [bf3_pkg::DataW-1:0]   prdata,
   output logic                             pready
);
   import bf3_pkg::*;

   localparam logic RegWidth  = 1'b0;
   localparam logic RegHeight = 1'b1;

   logic [WidthW-1:0]  width_ff;
   logic [HeightW-1:0] height_ff;
   logic               csr_write;

   bf3_cmd_type cmd;
   bf3_sts_type sts;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WidthReset;
         height_ff <= HeightReset;
      end else if (csr_write) begin
         if (paddr[2] == RegWidth) begin
            width_ff <= pwdata[WidthW-1:0];
         end
         if (paddr[2] == RegHeight) begin
            height_ff <= pwdata[HeightW-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == RegHeight) ? DataW'(height_ff) : DataW'(width_ff);

   bf3_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .cmd         (cmd),
      .sts         (sts)
   );

   bf3_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_pixel     (req_pixel),
      .image_width   (width_ff),
      .image_height  (height_ff),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_smoothed  (rsp_smoothed),
      .rsp_row_end   (rsp_row_end),
      .rsp_image_end (rsp_image_end)
   );

`ifndef SYNTHESIS
   // never overwrite a result that has not been transferred
   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("output register loaded while holding an untaken result");

   a_image_end_is_row_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_image_end) |-> rsp_row_end)
      else $error("image end without row end");

   // drain mode only starts on the final pixel of the image
   a_drain_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(sts.draining) |-> $past(cmd.push_shift))
      else $error("drain mode entered outside a pixel push");
`endif

endmodule

`default_nettype wire
